>>> design/catmull_rom_cubic_eval_unit_defines.svh
// Assertion macros shared by the Catmull-Rom evaluator RTL.
`ifndef CATMULL_ROM_CUBIC_EVAL_UNIT_DEFINES_SVH
`define CATMULL_ROM_CUBIC_EVAL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crce assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CRCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crce assertion failed");

`endif

>>> design/crce_pkg.sv
// Shared constants and operation codes of the Catmull-Rom evaluator.
`default_nettype none
package crce_pkg;

  localparam int POINT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int GUARD_BITS      = 6;
  localparam int OP_WIDTH        = 2;

  localparam logic [OP_WIDTH-1:0] OP_VALUE     = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_SLOPE     = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_CURVATURE = 2'd2;

endpackage
`default_nettype wire

>>> design/crce_coef.sv
// Coefficient stages: exact doubled coefficients and per-operation Horner operands.
`default_nettype none
module crce_coef #(
  parameter int POINT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                                  clk,
  input  wire                                                  rst_n,
  input  wire                                                  en,
  input  wire                                                  vld_in,
  input  wire  [crce_pkg::OP_WIDTH-1:0]                        op_in,
  input  wire  [FRAC_BITS:0]                                   t_in,
  input  wire  signed [POINT_WIDTH-1:0]                        p0_in,
  input  wire  signed [POINT_WIDTH-1:0]                        p1_in,
  input  wire  signed [POINT_WIDTH-1:0]                        p2_in,
  input  wire  signed [POINT_WIDTH-1:0]                        p3_in,
  output logic                                                 vld_out,
  output logic [FRAC_BITS:0]                                   t_out,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   v0_out,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   a1_out,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   a2_out,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   a3_out
);
  import crce_pkg::*;

  localparam int W = POINT_WIDTH + GUARD_BITS;
  localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic signed [W-1:0] e0, e1, e2, e3, d12;
  logic signed [W-1:0] ca_nxt, cb_nxt, cc_nxt, p1x2_nxt;
  logic [FRAC_BITS:0]  t_sat_nxt;

  logic                vld_a_r;
  logic [OP_WIDTH-1:0] op_a_r;
  logic [FRAC_BITS:0]  t_a_r;
  logic signed [W-1:0] ca_r, cb_r, cc_r, p1x2_r;

  logic signed [W-1:0] ca3, ca6, cb2;
  logic signed [W-1:0] v0_nxt, a1_nxt, a2_nxt, a3_nxt;

  logic                vld_b_r;
  logic [FRAC_BITS:0]  t_b_r;
  logic signed [W-1:0] v0_r, a1_r, a2_r, a3_r;

  assign e0 = {{(W-POINT_WIDTH){p0_in[POINT_WIDTH-1]}}, p0_in};
  assign e1 = {{(W-POINT_WIDTH){p1_in[POINT_WIDTH-1]}}, p1_in};
  assign e2 = {{(W-POINT_WIDTH){p2_in[POINT_WIDTH-1]}}, p2_in};
  assign e3 = {{(W-POINT_WIDTH){p3_in[POINT_WIDTH-1]}}, p3_in};

  assign d12      = e1 - e2;
  assign ca_nxt   = (d12 <<< 1) + d12 + e3 - e0;
  assign cb_nxt   = (e2 <<< 2) + (e0 <<< 1) - e3 - (e1 <<< 2) - e1;
  assign cc_nxt   = e2 - e0;
  assign p1x2_nxt = e1 <<< 1;
  assign t_sat_nxt = (t_in > T_ONE) ? T_ONE : t_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_a_r <= op_in;
      t_a_r  <= t_sat_nxt;
      ca_r   <= ca_nxt;
      cb_r   <= cb_nxt;
      cc_r   <= cc_nxt;
      p1x2_r <= p1x2_nxt;
    end
  end

  // Each operation becomes three uniform steps v = round(v * t) + a.
  assign ca3 = (ca_r <<< 1) + ca_r;
  assign ca6 = ca3 <<< 1;
  assign cb2 = cb_r <<< 1;

  always_comb begin
    unique case (op_a_r)
      OP_VALUE: begin
        v0_nxt = ca_r;
        a1_nxt = cb_r;
        a2_nxt = cc_r;
        a3_nxt = p1x2_r;
      end
      OP_SLOPE: begin
        v0_nxt = '0;
        a1_nxt = ca3;
        a2_nxt = cb2;
        a3_nxt = cc_r;
      end
      OP_CURVATURE: begin
        v0_nxt = '0;
        a1_nxt = '0;
        a2_nxt = ca6;
        a3_nxt = cb2;
      end
      default: begin
        v0_nxt = '0;
        a1_nxt = '0;
        a2_nxt = '0;
        a3_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_b_r <= t_a_r;
      v0_r  <= v0_nxt;
      a1_r  <= a1_nxt;
      a2_r  <= a2_nxt;
      a3_r  <= a3_nxt;
    end
  end

  assign vld_out = vld_b_r;
  assign t_out   = t_b_r;
  assign v0_out  = v0_r;
  assign a1_out  = a1_r;
  assign a2_out  = a2_r;
  assign a3_out  = a3_r;

endmodule
`default_nettype wire

>>> design/crce_step.sv
// One Horner step: registered multiply by t, then round to nearest and add.
`default_nettype none
module crce_step #(
  parameter int POINT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                                  clk,
  input  wire                                                  rst_n,
  input  wire                                                  en,
  input  wire                                                  vld_in,
  input  wire  signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   v_in,
  input  wire  [FRAC_BITS:0]                                   t_in,
  input  wire  signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   add_in,
  output logic                                                 vld_out,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   v_out
);
  import crce_pkg::*;

  localparam int W  = POINT_WIDTH + GUARD_BITS;
  localparam int PW = W + FRAC_BITS + 2;
  localparam logic [PW-1:0] RND = {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [FRAC_BITS+1:0] t_s;
  logic signed [PW-1:0]        prod_nxt;
  logic [PW-1:0]               rnd_sum;
  logic signed [W-1:0]         v_nxt;

  logic                        vld_m_r;
  logic signed [PW-1:0]        prod_r;
  logic signed [W-1:0]         add_r;
  logic                        vld_r;
  logic signed [W-1:0]         v_r;

  assign t_s      = {1'b0, t_in};
  assign prod_nxt = PW'(v_in) * PW'(t_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_m_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (en) begin
      vld_m_r <= vld_in;
      vld_r   <= vld_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      add_r  <= add_in;
      v_r    <= v_nxt;
    end
  end

  // The rounded product always fits the internal width, so the shift is a part-select.
  assign rnd_sum = prod_r + RND;
  assign v_nxt   = $signed(rnd_sum[FRAC_BITS +: W]) + add_r;

  assign vld_out = vld_r;
  assign v_out   = v_r;

endmodule
`default_nettype wire

>>> design/catmull_rom_cubic_eval_unit.sv
// Top level of the Catmull-Rom segment evaluator pipeline.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready  | op, t_param, four control points
//   out_    | output    | out_valid/out_ready  | curve_result
//
// Every transaction passes from input to result through two coefficient stages,
// three Horner steps of two stages each (multiply, then round and add), and the
// halving output register. One transaction is accepted per cycle while in_ready
// is high. Reset clears only the valid bits of the stages.
// A stall on the result side freezes the whole pipeline; in_ready is low exactly
// while a result is held and out_ready is low.
`default_nettype none
`include "catmull_rom_cubic_eval_unit_defines.svh"
module catmull_rom_cubic_eval_unit #(
  parameter int POINT_WIDTH = crce_pkg::POINT_WIDTH_DEF,
  parameter int FRAC_BITS   = crce_pkg::FRAC_BITS_DEF
) (
  input  wire                                                  clk,
  input  wire                                                  rst_n,
  input  wire                                                  in_valid,
  output logic                                                 in_ready,
  input  wire  [crce_pkg::OP_WIDTH-1:0]                        in_op,
  input  wire  [FRAC_BITS:0]                                   in_t_param,
  input  wire  signed [POINT_WIDTH-1:0]                        in_point_before,
  input  wire  signed [POINT_WIDTH-1:0]                        in_point_start,
  input  wire  signed [POINT_WIDTH-1:0]                        in_point_end,
  input  wire  signed [POINT_WIDTH-1:0]                        in_point_after,
  output logic                                                 out_valid,
  input  wire                                                  out_ready,
  output logic signed [POINT_WIDTH+crce_pkg::GUARD_BITS-1:0]   out_curve_result
);
  import crce_pkg::*;

  localparam int W = POINT_WIDTH + GUARD_BITS;

  logic                en;
  logic                c_vld;
  logic [FRAC_BITS:0]  c_t;
  logic signed [W-1:0] c_v0, c_a1, c_a2, c_a3;

  logic [FRAC_BITS:0]  t_d_r  [4];
  logic signed [W-1:0] a2_d_r [2];
  logic signed [W-1:0] a3_d_r [4];

  logic                s1_vld, s2_vld, s3_vld;
  logic signed [W-1:0] s1_v, s2_v, s3_v;

  logic signed [W:0]   inc;
  logic                out_vld_r;
  logic signed [W-1:0] out_res_r;

  assign en       = out_ready || !out_vld_r;
  assign in_ready = en;

  crce_coef #(
    .POINT_WIDTH(POINT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (in_valid),
    .op_in  (in_op),
    .t_in   (in_t_param),
    .p0_in  (in_point_before),
    .p1_in  (in_point_start),
    .p2_in  (in_point_end),
    .p3_in  (in_point_after),
    .vld_out(c_vld),
    .t_out  (c_t),
    .v0_out (c_v0),
    .a1_out (c_a1),
    .a2_out (c_a2),
    .a3_out (c_a3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_d_r[0]  <= c_t;
      t_d_r[1]  <= t_d_r[0];
      t_d_r[2]  <= t_d_r[1];
      t_d_r[3]  <= t_d_r[2];
      a2_d_r[0] <= c_a2;
      a2_d_r[1] <= a2_d_r[0];
      a3_d_r[0] <= c_a3;
      a3_d_r[1] <= a3_d_r[0];
      a3_d_r[2] <= a3_d_r[1];
      a3_d_r[3] <= a3_d_r[2];
    end
  end

  crce_step #(
    .POINT_WIDTH(POINT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (c_vld),
    .v_in   (c_v0),
    .t_in   (c_t),
    .add_in (c_a1),
    .vld_out(s1_vld),
    .v_out  (s1_v)
  );

  crce_step #(
    .POINT_WIDTH(POINT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (s1_vld),
    .v_in   (s1_v),
    .t_in   (t_d_r[1]),
    .add_in (a2_d_r[1]),
    .vld_out(s2_vld),
    .v_out  (s2_v)
  );

  crce_step #(
    .POINT_WIDTH(POINT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step3 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_in (s2_vld),
    .v_in   (s2_v),
    .t_in   (t_d_r[3]),
    .add_in (a3_d_r[3]),
    .vld_out(s3_vld),
    .v_out  (s3_v)
  );

  // The internal value carries one extra fraction bit; halve it with ties rounded up.
  assign inc = {s3_v[W-1], s3_v} + {{W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= inc[W:1];
    end
  end

  assign out_valid        = out_vld_r;
  assign out_curve_result = out_res_r;

  `CRCE_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)
  `CRCE_ASSERT_NEXT(a_stall_freeze, !in_ready, $stable(s3_vld) && $stable(s3_v) && $stable(c_vld))
  `CRCE_ASSERT_NEXT(a_bubble_moves, in_ready && !s3_vld, !out_valid)

endmodule
`default_nettype wire

>>> tb/catmull_rom_cubic_eval_unit_test.sv
// Self-checking testbench for the Catmull-Rom segment evaluator pipeline.
`timescale 1ns / 1ps
module catmull_rom_cubic_eval_unit_test;

  localparam int PW    = crce_pkg::POINT_WIDTH_DEF;
  localparam int FRAC  = crce_pkg::FRAC_BITS_DEF;
  localparam int OUT_W = PW + crce_pkg::GUARD_BITS;
  localparam int T_ONE = 1 << FRAC;
  localparam int T_TOP = (1 << (FRAC + 1)) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 650;

  localparam logic [crce_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [PW-1:0] POINT_MIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [PW-1:0] POINT_MAX = {1'b0, {(PW-1){1'b1}}};

  typedef logic signed [95:0] wide_t;
  typedef logic [FRAC:0] tparam_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [crce_pkg::OP_WIDTH-1:0]       in_op = crce_pkg::OP_VALUE;
  logic [FRAC:0]                       in_t_param = '0;
  logic signed [PW-1:0]                in_point_before = '0;
  logic signed [PW-1:0]                in_point_start = '0;
  logic signed [PW-1:0]                in_point_end = '0;
  logic signed [PW-1:0]                in_point_after = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [OUT_W-1:0]             out_curve_result;

  int  send_idle_pct = 38;
  int  recv_idle_pct = 45;
  bit  hold_off = 1'b0;
  int  cycles = 0;

  logic [crce_pkg::OP_WIDTH-1:0] all_ops [4] =
    '{crce_pkg::OP_VALUE, crce_pkg::OP_SLOPE, crce_pkg::OP_CURVATURE, OP_UNUSED};

  class curve_scoreboard;
    logic [OUT_W-1:0] expected_curve [$];
    int mismatches = 0;

    function wide_t round_product(wide_t x, wide_t t);
      return (x * t + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function logic [OUT_W-1:0] predict_curve(logic [crce_pkg::OP_WIDTH-1:0] op,
                                             logic [FRAC:0] t,
                                             logic signed [PW-1:0] p0,
                                             logic signed [PW-1:0] p1,
                                             logic signed [PW-1:0] p2,
                                             logic signed [PW-1:0] p3);
      wide_t w0, w1, w2, w3, tt, ca, cb, cc, acc;
      w0 = wide_t'(p0);
      w1 = wide_t'(p1);
      w2 = wide_t'(p2);
      w3 = wide_t'(p3);
      tt = (t > T_ONE) ? wide_t'(T_ONE) : wide_t'(t);
      ca = 3 * (w1 - w2) + (w3 - w0);
      cb = 4 * w2 + 2 * w0 - w3 - 5 * w1;
      cc = w2 - w0;
      case (op)
        crce_pkg::OP_VALUE: begin
          acc = round_product(ca, tt) + cb;
          acc = round_product(acc, tt) + cc;
          acc = round_product(acc, tt) + 2 * w1;
          acc = (acc + 1) >>> 1;
        end
        crce_pkg::OP_SLOPE: begin
          acc = round_product(3 * ca, tt) + 2 * cb;
          acc = round_product(acc, tt) + cc;
          acc = (acc + 1) >>> 1;
        end
        crce_pkg::OP_CURVATURE: begin
          acc = round_product(6 * ca, tt) + 2 * cb;
          acc = (acc + 1) >>> 1;
        end
        default: begin
          acc = '0;
        end
      endcase
      return acc[OUT_W-1:0];
    endfunction

    function void note_input(logic [crce_pkg::OP_WIDTH-1:0] op, logic [FRAC:0] t,
                             logic signed [PW-1:0] p0, logic signed [PW-1:0] p1,
                             logic signed [PW-1:0] p2, logic signed [PW-1:0] p3);
      expected_curve.push_back(predict_curve(op, t, p0, p1, p2, p3));
    endfunction

    function void check_result(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] want;
      if (expected_curve.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d with no transaction pending", $signed(actual));
      end else begin
        want = expected_curve.pop_front();
        if (actual !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("curve_result mismatch: expected %0d, actual %0d",
                     $signed(want), $signed(actual));
        end
      end
    endfunction
  endclass

  curve_scoreboard sb = new;

  catmull_rom_cubic_eval_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_t_param       (in_t_param),
    .in_point_before  (in_point_before),
    .in_point_start   (in_point_start),
    .in_point_end     (in_point_end),
    .in_point_after   (in_point_after),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_curve_result (out_curve_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_op, in_t_param, in_point_before, in_point_start,
                      in_point_end, in_point_after);
      if (out_valid && out_ready)
        sb.check_result(out_curve_result);
    end
  end

  always @(negedge clk) begin
    if (hold_off)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_curve_item(input logic [crce_pkg::OP_WIDTH-1:0] op,
                                 input logic [FRAC:0] t,
                                 input logic signed [PW-1:0] p0,
                                 input logic signed [PW-1:0] p1,
                                 input logic signed [PW-1:0] p2,
                                 input logic signed [PW-1:0] p3);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_t_param      <= t;
    in_point_before <= p0;
    in_point_start  <= p1;
    in_point_end    <= p2;
    in_point_after  <= p3;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [PW-1:0] random_point();
    case ($urandom_range(5))
      0: return POINT_MIN;
      1: return POINT_MAX;
      2: return PW'($signed($urandom_range(2000)) - 1000);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic send_random_items(input int count);
    logic [crce_pkg::OP_WIDTH-1:0] op;
    logic [FRAC:0] t;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(15) == 0) ? OP_UNUSED : all_ops[$urandom_range(2)];
      case ($urandom_range(7))
        0: t = '0;
        1: t = tparam_t'(T_ONE);
        2: t = tparam_t'($urandom_range(T_TOP, T_ONE + 1));
        default: t = tparam_t'($urandom_range(T_ONE));
      endcase
      send_curve_item(op, t, random_point(), random_point(), random_point(),
                      random_point());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < 4; k++) begin
      send_curve_item(all_ops[k], '0, POINT_MIN, POINT_MAX, POINT_MIN, POINT_MAX);
      send_curve_item(all_ops[k], tparam_t'(T_ONE), POINT_MAX, POINT_MIN, POINT_MAX,
                      POINT_MIN);
      send_curve_item(all_ops[k], tparam_t'(T_TOP), POINT_MIN, POINT_MIN, POINT_MAX,
                      POINT_MAX);
      send_curve_item(all_ops[k], tparam_t'(T_ONE / 2), 1, -3, 5, -7);
    end
    send_curve_item(crce_pkg::OP_VALUE, tparam_t'(1), POINT_MAX, POINT_MAX, POINT_MAX,
                    POINT_MAX);
    send_curve_item(crce_pkg::OP_SLOPE, tparam_t'(T_ONE - 1), POINT_MIN, POINT_MIN,
                    POINT_MIN, POINT_MIN);
    send_curve_item(crce_pkg::OP_CURVATURE, tparam_t'(T_ONE / 2 + 1), 0, 0, 0, 0);
    send_curve_item(crce_pkg::OP_VALUE, tparam_t'(3 * T_ONE / 4), 3, 0, -1, 2);

    send_random_items(PHASE_ITEMS);

    send_idle_pct = 45;
    recv_idle_pct = 38;
    send_random_items(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      send_random_items(PHASE_ITEMS);
      begin
        repeat (100) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join

    in_valid <= 1'b0;
    while (sb.expected_curve.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.expected_curve.size() != 0)
      $display("%0d transactions never produced a result", sb.expected_curve.size());
    if (sb.mismatches == 0 && sb.expected_curve.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
